// ===== design/lzwc_pkg.sv =====
// ----------------------------------------------------------------------------
// lzwc_pkg - shared types and constants of the LZW record compressor
// Code values, dictionary sizing defaults, phase codes and the command and
// status structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lzwc_pkg;

	// default sizing
	localparam int MAX_CODE_BITS = 11;
	localparam int DICT_DEPTH    = 2459;

	// special codes and start values
	localparam int CODE_END    = 256;
	localparam int CODE_BUMP   = 257;
	localparam int CODE_FLUSH  = 258;
	localparam int CODE_FIRST  = 259;
	localparam int START_WIDTH = 9;
	localparam int START_LIMIT = 511;

	// emission phases: which code is sent and what follows its drain
	localparam logic [2:0] PH_CUR    = 3'd0;
	localparam logic [2:0] PH_FLUSH  = 3'd1;
	localparam logic [2:0] PH_BUMP   = 3'd2;
	localparam logic [2:0] PH_FINCUR = 3'd3;
	localparam logic [2:0] PH_END    = 3'd4;

	typedef struct packed {
		logic       in_ready;
		logic       init_rec;
		logic       clr_step;
		logic       hash;
		logic       rd;
		logic       probe_step;
		logic       insert;
		logic       hit_take;
		logic [2:0] code_sel;
		logic       emit_load;
		logic       drain_pop;
		logic       pad;
		logic       cur_ch;
		logic       bump;
		logic       dict_reset;
		logic       close_rec;
		logic       set_abandon;
		logic       push_fail;
	} lzwc_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic first;
		logic last;
		logic in_record;
		logic abandoned;
		logic clr_last;
		logic rd_used;
		logic rd_match;
		logic probe_last;
		logic over_top;
		logic over_limit;
		logic drain_need;
		logic budget_zero;
		logic out_free;
	} lzwc_sts_t;

endpackage

// ===== design/lzwc_ram.sv =====
// ----------------------------------------------------------------------------
// lzwc_ram - generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module lzwc_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 2459
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/lzwc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lzwc_ctrl - sequencing state machine of the LZW compressor
// Steps each input word through dispatch, dictionary probe, code emission,
// byte draining, dictionary clearing, record close and the failure word.
// ----------------------------------------------------------------------------
module lzwc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  lzwc_pkg::lzwc_sts_t sts,
	output lzwc_pkg::lzwc_cmd_t cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DISP  = 4'd1;
	localparam logic [3:0] ST_CLEAR = 4'd2;
	localparam logic [3:0] ST_RD    = 4'd3;
	localparam logic [3:0] ST_CMP   = 4'd4;
	localparam logic [3:0] ST_LOAD  = 4'd5;
	localparam logic [3:0] ST_DRAIN = 4'd6;
	localparam logic [3:0] ST_FAIL  = 4'd7;

	logic [3:0] state_q, state_d;
	logic [2:0] phase_q, phase_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		cmd     = '0;
		cmd.code_sel = phase_q;
		cmd.pad      = (phase_q == lzwc_pkg::PH_END);
		unique case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.in_valid) begin
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				priority if (sts.first) begin
					cmd.init_rec = 1'b1;
					state_d      = ST_CLEAR;
				end else if (!sts.in_record) begin
					state_d = ST_IDLE;
				end else if (sts.abandoned) begin
					state_d = sts.last ? ST_FAIL : ST_IDLE;
				end else begin
					cmd.hash = 1'b1;
					state_d  = ST_RD;
				end
			end
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					phase_d = lzwc_pkg::PH_FINCUR;
					state_d = sts.last ? ST_LOAD : ST_IDLE;
				end
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				priority if (sts.rd_match) begin
					cmd.hit_take = 1'b1;
					phase_d      = lzwc_pkg::PH_FINCUR;
					state_d      = sts.last ? ST_LOAD : ST_IDLE;
				end else if (!sts.rd_used || sts.probe_last) begin
					cmd.insert = 1'b1;
					phase_d    = lzwc_pkg::PH_CUR;
					state_d    = ST_LOAD;
				end else begin
					cmd.probe_step = 1'b1;
					state_d        = ST_RD;
				end
			end
			ST_LOAD: begin
				cmd.emit_load = 1'b1;
				state_d       = ST_DRAIN;
			end
			ST_DRAIN: begin
				priority if (sts.drain_need) begin
					if (sts.budget_zero) begin
						cmd.set_abandon = 1'b1;
						state_d         = sts.last ? ST_FAIL : ST_IDLE;
					end else if (sts.out_free) begin
						cmd.drain_pop = 1'b1;
					end
				end else begin
					unique case (phase_q)
						lzwc_pkg::PH_CUR: begin
							cmd.cur_ch = 1'b1;
							priority if (sts.over_top) begin
								phase_d = lzwc_pkg::PH_FLUSH;
								state_d = ST_LOAD;
							end else if (sts.over_limit) begin
								phase_d = lzwc_pkg::PH_BUMP;
								state_d = ST_LOAD;
							end else begin
								phase_d = lzwc_pkg::PH_FINCUR;
								state_d = sts.last ? ST_LOAD : ST_IDLE;
							end
						end
						lzwc_pkg::PH_FLUSH: begin
							cmd.dict_reset = 1'b1;
							state_d        = ST_CLEAR;
						end
						lzwc_pkg::PH_BUMP: begin
							cmd.bump = 1'b1;
							phase_d  = lzwc_pkg::PH_FINCUR;
							state_d  = sts.last ? ST_LOAD : ST_IDLE;
						end
						lzwc_pkg::PH_FINCUR: begin
							phase_d = lzwc_pkg::PH_END;
							state_d = ST_LOAD;
						end
						default: begin
							cmd.close_rec = 1'b1;
							state_d       = ST_IDLE;
						end
					endcase
				end
			end
			ST_FAIL: begin
				if (sts.out_free) begin
					cmd.push_fail = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= lzwc_pkg::PH_CUR;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

endmodule

// ===== design/lzwc_dpath.sv =====
// ----------------------------------------------------------------------------
// lzwc_dpath - datapath of the LZW compressor
// Input latch, hashed dictionary with secondary probe, code packer, byte
// budget and the output word register.
// ----------------------------------------------------------------------------
module lzwc_dpath #(
	parameter int MAX_CODE_BITS = lzwc_pkg::MAX_CODE_BITS,
	parameter int DICT_DEPTH    = lzwc_pkg::DICT_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lzwc_pkg::lzwc_cmd_t cmd,
	output lzwc_pkg::lzwc_sts_t sts,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [23:0]         s_axis_tdata,
	input  logic [0:0]          s_axis_tuser,
	input  logic                s_axis_tlast,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [23:0]         m_axis_tdata,
	output logic [0:0]          m_axis_tuser,
	output logic                m_axis_tlast
);

	localparam int CB = MAX_CODE_BITS;
	localparam int IW = $clog2(DICT_DEPTH);
	localparam int RW = 1 + 2 * CB + 8;

	// latched input word
	logic [7:0]  ch_q;
	logic        first_q, last_q;
	logic [15:0] len_q;

	// coder state
	logic [CB-1:0] cur_q;
	logic [CB:0]   nfc_q;
	logic [3:0]    cw_q;
	logic [CB-1:0] limit_q;
	logic [31:0]   acc_q;
	logic [5:0]    held_q;
	logic [15:0]   left_q, count_q;
	logic          abandoned_q, in_record_q;

	// probe state
	logic [IW-1:0] idx_q, off_q, n_q, clr_q;

	// output word register
	logic        ovalid_q;
	logic [7:0]  obyte_q;
	logic [15:0] olen_q;
	logic        oeor_q, ofail_q;

	// dictionary memory
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [RW-1:0] ram_wdata, ram_rdata;
	logic          rd_used;
	logic [CB-1:0] rd_code, rd_prefix;
	logic [7:0]    rd_ch;

	assign {rd_used, rd_code, rd_prefix, rd_ch} = ram_rdata;
	assign ram_we    = cmd.clr_step | (cmd.insert & ~rd_used);
	assign ram_waddr = cmd.clr_step ? clr_q : idx_q;
	assign ram_wdata = cmd.clr_step ? '0 : {1'b1, nfc_q[CB-1:0], cur_q, ch_q};

	lzwc_ram #(
		.WIDTH(RW),
		.DEPTH(DICT_DEPTH)
	) u_dict (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.rd),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	// hash of (current string, byte), folded into the table, plus probe offset and next index
	logic [CB-1:0] hmix;
	logic [IW-1:0] hidx, hoff, idx_next;
	always_comb begin
		hmix = {ch_q, {(CB - 8){1'b0}}} ^ cur_q;
		hidx = IW'(hmix);
		if ((IW + 1)'(hidx) >= (IW + 1)'(DICT_DEPTH)) begin
			hidx = IW'((IW + 1)'(hidx) - (IW + 1)'(DICT_DEPTH));
		end
		hoff = (hidx == '0) ? IW'(1) : IW'((IW + 1)'(DICT_DEPTH) - (IW + 1)'(hidx));
		if (idx_q >= off_q) begin
			idx_next = idx_q - off_q;
		end else begin
			idx_next = IW'((IW + 1)'(idx_q) + (IW + 1)'(DICT_DEPTH) - (IW + 1)'(off_q));
		end
	end

	// code to send, masked to the current width
	logic [CB-1:0] code_sel;
	logic [CB:0]   code_mask;
	logic [5:0]    held_new;
	always_comb begin
		unique case (cmd.code_sel)
			lzwc_pkg::PH_FLUSH: code_sel = CB'(lzwc_pkg::CODE_FLUSH);
			lzwc_pkg::PH_BUMP:  code_sel = CB'(lzwc_pkg::CODE_BUMP);
			lzwc_pkg::PH_END:   code_sel = CB'(lzwc_pkg::CODE_END);
			default:            code_sel = cur_q;
		endcase
		code_mask = ((CB + 1)'(1) << cw_q) - (CB + 1)'(1);
		held_new  = held_q + 6'(cw_q);
	end

	logic out_free, drain_need, last_out;
	assign out_free   = ~ovalid_q | m_axis_tready;
	assign drain_need = cmd.pad ? (held_q != '0) : (held_q >= 6'd8);
	assign last_out   = cmd.pad & (held_q <= 6'd8);

	// status to the controller
	always_comb begin
		sts             = '0;
		sts.in_valid    = s_axis_tvalid;
		sts.first       = first_q;
		sts.last        = last_q;
		sts.in_record   = in_record_q;
		sts.abandoned   = abandoned_q;
		sts.clr_last    = (clr_q == IW'(DICT_DEPTH - 1));
		sts.rd_used     = rd_used;
		sts.rd_match    = rd_used & (rd_prefix == cur_q) & (rd_ch == ch_q);
		sts.probe_last  = (n_q == IW'(DICT_DEPTH - 1));
		sts.over_top    = nfc_q[CB];
		sts.over_limit  = nfc_q > {1'b0, limit_q};
		sts.drain_need  = drain_need;
		sts.budget_zero = (left_q == '0);
		sts.out_free    = out_free;
	end

	// latch the input word
	assign s_axis_tready = cmd.in_ready;
	always_ff @(posedge clk) begin
		if (cmd.in_ready && s_axis_tvalid) begin
			ch_q    <= s_axis_tdata[7:0];
			len_q   <= s_axis_tdata[23:8];
			first_q <= s_axis_tuser[0];
			last_q  <= s_axis_tlast;
		end
	end

	// probe pointers and clear sweep
	always_ff @(posedge clk) begin
		if (cmd.hash) begin
			idx_q <= hidx;
			off_q <= hoff;
			n_q   <= '0;
		end else if (cmd.probe_step) begin
			idx_q <= idx_next;
			n_q   <= n_q + IW'(1);
		end
		if (cmd.init_rec || cmd.dict_reset) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + IW'(1);
		end
	end

	// coder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			nfc_q       <= (CB + 1)'(lzwc_pkg::CODE_FIRST);
			cw_q        <= 4'(lzwc_pkg::START_WIDTH);
			limit_q     <= CB'(lzwc_pkg::START_LIMIT);
			acc_q       <= '0;
			held_q      <= '0;
			left_q      <= '0;
			count_q     <= '0;
			abandoned_q <= 1'b0;
			in_record_q <= 1'b0;
		end else begin
			if (cmd.init_rec) begin
				cur_q       <= CB'(ch_q);
				acc_q       <= '0;
				held_q      <= '0;
				left_q      <= len_q;
				count_q     <= '0;
				abandoned_q <= 1'b0;
				in_record_q <= 1'b1;
			end
			if (cmd.init_rec || cmd.dict_reset) begin
				nfc_q   <= (CB + 1)'(lzwc_pkg::CODE_FIRST);
				cw_q    <= 4'(lzwc_pkg::START_WIDTH);
				limit_q <= CB'(lzwc_pkg::START_LIMIT);
			end
			if (cmd.insert) begin
				nfc_q <= nfc_q + (CB + 1)'(1);
			end
			if (cmd.hit_take) begin
				cur_q <= rd_code;
			end
			if (cmd.cur_ch) begin
				cur_q <= CB'(ch_q);
			end
			if (cmd.bump) begin
				cw_q    <= cw_q + 4'd1;
				limit_q <= {limit_q[CB-2:0], 1'b1};
			end
			// pack the code below the bits already held
			if (cmd.emit_load) begin
				held_q <= held_new;
				acc_q  <= acc_q | (32'(code_sel & code_mask[CB-1:0]) << (6'd32 - held_new));
			end
			// send the top byte
			if (cmd.drain_pop) begin
				acc_q   <= acc_q << 8;
				held_q  <= (held_q <= 6'd8) ? 6'd0 : held_q - 6'd8;
				left_q  <= left_q - 16'd1;
				count_q <= count_q + 16'd1;
			end
			if (cmd.set_abandon) begin
				abandoned_q <= 1'b1;
			end
			if (cmd.close_rec || cmd.push_fail) begin
				in_record_q <= 1'b0;
				acc_q       <= '0;
				held_q      <= '0;
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.drain_pop || cmd.push_fail) begin
			ovalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.drain_pop) begin
			obyte_q <= acc_q[31:24];
			oeor_q  <= last_out;
			ofail_q <= 1'b0;
			olen_q  <= last_out ? count_q + 16'd1 : 16'd0;
		end else if (cmd.push_fail) begin
			obyte_q <= 8'd0;
			oeor_q  <= 1'b1;
			ofail_q <= 1'b1;
			olen_q  <= count_q;
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {olen_q, obyte_q};
	assign m_axis_tuser  = ofail_q;
	assign m_axis_tlast  = oeor_q;

endmodule

// ===== design/lzw_variable_width_compressor_unit.sv =====
// Sequence: each accepted byte is dispatched, then probed (dictionary read, then compare);
// a hit takes the stored code; a miss loads its code and pops one word per cycle
// whenever the output is free. A new byte is accepted only once the last one is handled;
// each further probe repeats the read and compare, each further code is loaded and drained.
// A first byte starts a clear sweep of all DICT_DEPTH entries (2459); a flush code adds another.
// Reset: asynchronous, active low; clears control state, no record open, dictionary untouched.
// ----------------------------------------------------------------------------
// lzw_variable_width_compressor_unit - LZW record compressor, 9 to 11 bit codes
// Top level: joins the sequencing controller to the datapath.
// ----------------------------------------------------------------------------
module lzw_variable_width_compressor_unit #(
	parameter int MAX_CODE_BITS = lzwc_pkg::MAX_CODE_BITS,
	parameter int DICT_DEPTH    = lzwc_pkg::DICT_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [7:0] in_byte, [23:8] record_len
	input  logic [0:0]  s_axis_tuser,  // [0] first_byte
	input  logic        s_axis_tlast,  // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [7:0] out_byte, [23:8] compressed_len
	output logic [0:0]  m_axis_tuser,  // [0] failed
	output logic        m_axis_tlast   // end_of_record
);

	lzwc_pkg::lzwc_cmd_t cmd;
	lzwc_pkg::lzwc_sts_t sts;

	lzwc_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.sts   (sts),
		.cmd   (cmd)
	);

	lzwc_dpath #(
		.MAX_CODE_BITS(MAX_CODE_BITS),
		.DICT_DEPTH   (DICT_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule
